[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/mwas_pkg.sv]
// ----------------------------------------------------------------------------
// mwas_pkg
// Shared types and constants of the window average / slew unit.
// ----------------------------------------------------------------------------
package mwas_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int NUM_LANES  = 8;
    localparam int TDATA_W    = SAMPLE_W * NUM_LANES;
    localparam int DRIFT_W    = 15;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_RATE_EN = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_DRIFT   = 1'd1;

    localparam logic [DRIFT_W-1:0] DRIFT_RST = 15'd16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

[rtl/core/mwas_ram.sv]
// ----------------------------------------------------------------------------
// mwas_ram
// Simple dual-port RAM, one write port, one read port, registered read
// (read-first when both ports hit the same address).
// ----------------------------------------------------------------------------
module mwas_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

[rtl/core/multichannel_window_average_slew_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_window_average_slew_unit
// Per-channel moving average over WINDOW frames with optional slew limit.
// ----------------------------------------------------------------------------
// One frame (CHANNELS signed samples) is taken per cycle while s_tready is
// high, and one result is returned per frame. The pipeline is: frame RAM
// read of the oldest row, running-sum update, reciprocal multiply, quotient
// correction, baseline update into the output register. Each stage moves on
// its own, so the input keeps taking frames while a result waits on m_tready,
// until all five stages hold a frame. The frame RAM has no clearing pass
// after reset: the oldest row is only subtracted once WINDOW frames have
// been seen. Until then ready (m_tuser) is 0 and the baselines read zero.
`include "assert_macros.svh"

module multichannel_window_average_slew_unit
    import mwas_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input frame
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // sample_0 .. sample_7, 16 bits each
    // result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // baseline_0 .. baseline_7, 16 bits each
    output logic [0:0]            m_tuser,   // ready_res
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LANE_W = CHANNELS * SAMPLE_W;
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 2);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int PROD_W = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);
    localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    // ---------------- configuration ----------------
    logic                  rate_en_reg;
    logic [DRIFT_W-1:0]    drift_reg;
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic                  cfg_wr;

    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_en_reg <= 1'b0;
            drift_reg   <= DRIFT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RATE_EN: rate_en_reg <= pwdata[0];
                REG_DRIFT:   drift_reg   <= pwdata[DRIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RATE_EN: prdata = {{(APB_DATA_W-1){1'b0}}, rate_en_reg};
            REG_DRIFT:   prdata = {{(APB_DATA_W-DRIFT_W){1'b0}}, drift_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- stage flow control ----------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, o_valid_reg;
    logic take_a, take_b, take_c, take_d, take_out;
    logic s_accept;

    assign take_out = !o_valid_reg || m_tready;
    assign take_d   = !d_valid_reg || take_out;
    assign take_c   = !c_valid_reg || take_d;
    assign take_b   = !b_valid_reg || take_c;
    assign take_a   = !a_valid_reg || take_b;
    assign s_tready = take_a;
    assign s_accept = s_tvalid && take_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (take_a)   a_valid_reg <= s_tvalid;
            if (take_b)   b_valid_reg <= a_valid_reg;
            if (take_c)   c_valid_reg <= b_valid_reg;
            if (take_d)   d_valid_reg <= c_valid_reg;
            if (take_out) o_valid_reg <= d_valid_reg;
        end
    end

    // ---------------- stage A: frame RAM ----------------
    logic [PTR_W-1:0]  ptr_reg;
    logic [LANE_W-1:0] a_data_reg;
    logic [LANE_W-1:0] a_old;

    // write the new row and read the row it replaces at the same address
    mwas_ram #(
        .WIDTH (LANE_W),
        .DEPTH (WINDOW)
    ) u_frame_ram (
        .clk     (aclk),
        .wr_en   (s_accept),
        .wr_addr (ptr_reg),
        .wr_data (s_tdata[LANE_W-1:0]),
        .rd_en   (s_accept),
        .rd_addr (ptr_reg),
        .rd_data (a_old)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (s_accept) begin
            ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_data_reg <= s_tdata[LANE_W-1:0];
        end
    end

    // ---------------- stage B: running sums ----------------
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    full_before;
    logic signed [SUM_W-1:0] sum_reg  [CHANNELS];
    logic signed [SUM_W-1:0] sum_next [CHANNELS];
    logic signed [SUM_W-1:0] b_sum_reg [CHANNELS];
    logic                    b_ready_reg, b_limit_reg;
    logic                    a_move;

    assign a_move      = a_valid_reg && take_b;
    assign full_before = cnt_reg >= WIN_C;
    assign cnt_next    = (cnt_reg <= WIN_C) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        logic [SAMPLE_W-1:0] new_s;
        logic [SAMPLE_W-1:0] old_s;
        logic [SUM_W-1:0]    old_ext;
        for (int c = 0; c < CHANNELS; c++) begin
            new_s   = a_data_reg[c*SAMPLE_W +: SAMPLE_W];
            old_s   = a_old[c*SAMPLE_W +: SAMPLE_W];
            old_ext = full_before ? {{(SUM_W-SAMPLE_W){old_s[SAMPLE_W-1]}}, old_s} : '0;
            sum_next[c] = sum_reg[c]
                        + $signed({{(SUM_W-SAMPLE_W){new_s[SAMPLE_W-1]}}, new_s})
                        - $signed(old_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (a_move) begin
            cnt_reg <= cnt_next;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_b) begin
            b_ready_reg <= cnt_next >= WIN_C;
            b_limit_reg <= rate_en_reg && (cnt_next > WIN_C);
            for (int c = 0; c < CHANNELS; c++) begin
                b_sum_reg[c] <= sum_next[c];
            end
        end
    end

    // ---------------- stage C: reciprocal multiply ----------------
    logic [SAMPLE_W-1:0] c_q0_reg  [CHANNELS];
    logic [SUM_W-1:0]    c_mag_reg [CHANNELS];
    logic                c_neg_reg [CHANNELS];
    logic                c_ready_reg, c_limit_reg;

    always_ff @(posedge aclk) begin
        logic [SUM_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        if (take_c) begin
            c_ready_reg <= b_ready_reg;
            c_limit_reg <= b_limit_reg;
            for (int c = 0; c < CHANNELS; c++) begin
                mag  = b_sum_reg[c][SUM_W-1] ? SUM_W'(-b_sum_reg[c]) : SUM_W'(b_sum_reg[c]);
                prod = PROD_W'(mag) * PROD_W'(RECIP);
                c_q0_reg[c]  <= prod[SUM_W +: SAMPLE_W];
                c_mag_reg[c] <= mag;
                c_neg_reg[c] <= b_sum_reg[c][SUM_W-1];
            end
        end
    end

    // ---------------- stage D: quotient correction, sign ----------------
    sample_t d_mean_reg [CHANNELS];
    logic    d_ready_reg, d_limit_reg;

    always_ff @(posedge aclk) begin
        logic [SUM_W-1:0]    rem;
        logic [SAMPLE_W-1:0] q;
        if (take_d) begin
            d_ready_reg <= c_ready_reg;
            d_limit_reg <= c_limit_reg;
            for (int c = 0; c < CHANNELS; c++) begin
                // reciprocal estimate is exact or one low
                rem = c_mag_reg[c] - SUM_W'(c_q0_reg[c]) * WIN_S;
                q   = (rem >= WIN_S) ? c_q0_reg[c] + 1'b1 : c_q0_reg[c];
                d_mean_reg[c] <= c_neg_reg[c] ? sample_t'(-q) : sample_t'(q);
            end
        end
    end

    // ---------------- output: baseline update ----------------
    sample_t             base_reg  [CHANNELS];
    sample_t             base_next [CHANNELS];
    logic [TDATA_W-1:0]  o_data_reg;
    logic [TDATA_W-1:0]  o_data_next;
    logic                o_ready_reg;
    logic                d_move;

    assign d_move = d_valid_reg && take_out;

    always_comb begin
        logic signed [SAMPLE_W:0] diff;
        logic [SAMPLE_W:0]        dmag;
        logic [SAMPLE_W:0]        step;
        o_data_next = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            diff = {d_mean_reg[c][SAMPLE_W-1], d_mean_reg[c]}
                 - {base_reg[c][SAMPLE_W-1], base_reg[c]};
            dmag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
            step = {{(SAMPLE_W+1-DRIFT_W){1'b0}}, drift_reg};
            if (!d_ready_reg) begin
                base_next[c] = base_reg[c];
            end else if (!d_limit_reg || (dmag < step)) begin
                base_next[c] = d_mean_reg[c];
            end else if (diff[SAMPLE_W]) begin
                base_next[c] = sample_t'({base_reg[c][SAMPLE_W-1], base_reg[c]} - step);
            end else begin
                base_next[c] = sample_t'({base_reg[c][SAMPLE_W-1], base_reg[c]} + step);
            end
            o_data_next[c*SAMPLE_W +: SAMPLE_W] = base_next[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                base_reg[c] <= '0;
            end
        end else if (d_move) begin
            for (int c = 0; c < CHANNELS; c++) begin
                base_reg[c] <= base_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_out) begin
            o_ready_reg <= d_ready_reg;
            o_data_reg  <= o_data_next;
        end
    end

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = o_data_reg;
    assign m_tuser[0] = o_ready_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPLIES(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(WINDOW + 1))
    `ASSERT_IMPLIES(a_idle_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)
    `ASSERT_IMPLIES(a_empty_takes, aclk, aresetn, !a_valid_reg, s_tready)
    `ASSERT_NEXT(a_out_loads, aclk, aresetn, d_valid_reg && take_out, m_tvalid)

endmodule
